// ===== sv/trb_pkg.sv =====
// Shared constants, codes and types for the transparent remap blitter.
package trb_pkg;

  localparam int ADDR_BITS       = 24;
  localparam int PALETTE_ENTRIES = 256;
  localparam int PAL_IDX_W       = $clog2(PALETTE_ENTRIES);
  localparam int COLOR_W         = 16;
  localparam int OUT_ADDR_W      = 24;
  localparam int DIM_W           = 16;
  localparam int BYTE_W          = 8;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 16;

  localparam logic [DIM_W-1:0]  STRIDE_RESET = DIM_W'(640);
  localparam logic [BYTE_W-1:0] KEY_RESET    = 8'hFF;

  // Input operation codes.
  localparam logic OP_PALETTE = 1'b0;
  localparam logic OP_STREAM  = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_ROW_STRIDE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEST_X     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEST_Y     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY        = 2'd3;

  // What the address walker reports for the stream byte now on the input.
  typedef struct packed {
    logic                 is_pixel;
    logic [ADDR_BITS-1:0] address;
    logic                 last;
  } walk_info_t;

endpackage

// ===== sv/trb_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module trb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/trb_walk.sv =====
// Header parser and destination address walker for the bitmap stream.
module trb_walk import trb_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [BYTE_W-1:0] stream_byte,
  input  logic [DIM_W-1:0]  row_stride,
  input  logic [DIM_W-1:0]  dest_x,
  input  logic [DIM_W-1:0]  dest_y,
  output walk_info_t        info
);

  typedef enum logic [2:0] {
    PH_W_LO,
    PH_W_HI,
    PH_H_LO,
    PH_H_HI,
    PH_PIXELS
  } phase_t;

  phase_t               phase;
  logic [DIM_W-1:0]     bitmap_width;
  logic [DIM_W-1:0]     bitmap_height;
  logic [DIM_W-1:0]     column_count;
  logic [DIM_W-1:0]     row_count;
  logic [ADDR_BITS-1:0] row_base;

  logic [DIM_W:0]       col_inc;
  logic [DIM_W:0]       row_inc;
  logic                 row_end;
  logic                 last;
  logic [DIM_W-1:0]     height_full;
  logic [2*DIM_W-1:0]   start_prod;
  logic [2*DIM_W:0]     start_sum;

  assign col_inc     = {1'b0, column_count} + (DIM_W+1)'(1);
  assign row_inc     = {1'b0, row_count} + (DIM_W+1)'(1);
  assign row_end     = (col_inc == {1'b0, bitmap_width});
  assign last        = row_end && (row_inc == {1'b0, bitmap_height});
  assign height_full = {stream_byte, bitmap_height[BYTE_W-1:0]};

  // Start address of the bitmap's top-left pixel, taken when the header completes.
  assign start_prod = (2*DIM_W)'(dest_y) * (2*DIM_W)'(row_stride);
  assign start_sum  = {1'b0, start_prod} + (2*DIM_W+1)'(dest_x);

  assign info.is_pixel = (phase == PH_PIXELS);
  assign info.address  = row_base + ADDR_BITS'(column_count);
  assign info.last     = last;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_W_LO;
      bitmap_width  <= '0;
      bitmap_height <= '0;
      column_count  <= '0;
      row_count     <= '0;
      row_base      <= '0;
    end else if (step) begin
      unique case (phase)
        PH_W_LO: begin
          bitmap_width <= {{(DIM_W-BYTE_W){1'b0}}, stream_byte};
          phase        <= PH_W_HI;
        end
        PH_W_HI: begin
          bitmap_width[DIM_W-1:BYTE_W] <= stream_byte;
          phase                        <= PH_H_LO;
        end
        PH_H_LO: begin
          bitmap_height <= {{(DIM_W-BYTE_W){1'b0}}, stream_byte};
          phase         <= PH_H_HI;
        end
        PH_H_HI: begin
          bitmap_height <= height_full;
          column_count  <= '0;
          row_count     <= '0;
          // An empty bitmap ends right after its header.
          if (bitmap_width == '0 || height_full == '0) begin
            phase <= PH_W_LO;
          end else begin
            phase    <= PH_PIXELS;
            row_base <= ADDR_BITS'(start_sum);
          end
        end
        PH_PIXELS: begin
          if (last) begin
            phase        <= PH_W_LO;
            column_count <= '0;
            row_count    <= '0;
          end else if (row_end) begin
            column_count <= '0;
            row_count    <= row_inc[DIM_W-1:0];
            row_base     <= row_base + ADDR_BITS'(row_stride);
          end else begin
            column_count <= col_inc[DIM_W-1:0];
          end
        end
        default: begin
          phase <= PH_W_LO;
        end
      endcase
    end
  end

endmodule

// ===== sv/transparent_remap_blit_top.sv =====
// Top level of the color-keyed palette remapping blitter.
//
//  channel  direction  handshake              payload
//  in       input      in_valid / in_ready    operation, stream_byte, palette_index,
//                                             palette_color
//  out      output     out_valid / out_ready  dest_address, pixel_color, write_enable,
//                                             bitmap_done
//  cfg      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One input transaction per cycle while in_ready is high; the palette RAM is read at the
// accepting edge and the output register loads when the read stage moves on. Loads and
// header bytes produce no output. A stalled output holds its register; the read stage
// behind it keeps one more pixel, after which in_ready drops until the output drains.
// Reset sets the header parser, valid flags and configuration registers to reset values;
// the palette is not cleared and needs no clearing pass. cfg_ready is always high.
module transparent_remap_blit_top import trb_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  operation,
  input  logic [BYTE_W-1:0]     stream_byte,
  input  logic [PAL_IDX_W-1:0]  palette_index,
  input  logic [COLOR_W-1:0]    palette_color,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [OUT_ADDR_W-1:0] dest_address,
  output logic [COLOR_W-1:0]    pixel_color,
  output logic                  write_enable,
  output logic                  bitmap_done,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [DIM_W-1:0]      row_stride;
  logic [DIM_W-1:0]      dest_x;
  logic [DIM_W-1:0]      dest_y;
  logic [BYTE_W-1:0]     transparent_key;

  walk_info_t            info;
  logic                  in_accept;
  logic                  stream_accept;
  logic                  pixel_accept;
  logic                  palette_write;

  logic                  s1_valid;
  logic [OUT_ADDR_W-1:0] s1_address;
  logic                  s1_we;
  logic                  s1_last;
  logic                  s1_move;
  logic [COLOR_W-1:0]    pal_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_stride      <= STRIDE_RESET;
      dest_x          <= '0;
      dest_y          <= '0;
      transparent_key <= KEY_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ROW_STRIDE: row_stride      <= cfg_data;
        REG_DEST_X:     dest_x          <= cfg_data;
        REG_DEST_Y:     dest_y          <= cfg_data;
        REG_KEY:        transparent_key <= cfg_data[BYTE_W-1:0];
        default:        ;
      endcase
    end
  end

  assign s1_move       = !out_valid || out_ready;
  assign in_ready      = !s1_valid || s1_move;
  assign in_accept     = in_valid && in_ready;
  assign stream_accept = in_accept && (operation == OP_STREAM);
  assign palette_write = in_accept && (operation == OP_PALETTE);
  assign pixel_accept  = stream_accept && info.is_pixel;

  trb_walk u_walk (
    .clk        (clk),
    .rst        (rst),
    .step       (stream_accept),
    .stream_byte(stream_byte),
    .row_stride (row_stride),
    .dest_x     (dest_x),
    .dest_y     (dest_y),
    .info       (info)
  );

  // Reads and writes come from distinct transactions, so a read always sees
  // every palette load accepted before it.
  trb_ram #(
    .WIDTH(COLOR_W),
    .DEPTH(PALETTE_ENTRIES)
  ) u_palette (
    .clk  (clk),
    .we   (palette_write),
    .waddr(palette_index),
    .wdata(palette_color),
    .re   (pixel_accept),
    .raddr(stream_byte[PAL_IDX_W-1:0]),
    .rdata(pal_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= pixel_accept;
    end
    if (pixel_accept) begin
      s1_address <= OUT_ADDR_W'(info.address);
      s1_we      <= (stream_byte != transparent_key);
      s1_last    <= info.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= s1_valid;
    end
    if (s1_move && s1_valid) begin
      dest_address <= s1_address;
      pixel_color  <= s1_we ? pal_rdata : '0;
      write_enable <= s1_we;
      bitmap_done  <= s1_last;
    end
  end

  // A pixel in the read stage is never dropped while the output is stalled.
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_move |=> s1_valid && $stable(s1_address) && $stable(s1_last))
    else $error("read stage lost or changed a stalled pixel");

  // Every accepted pixel reaches the read stage on the next cycle.
  a_pixel_enters: assert property (@(posedge clk) disable iff (rst)
    pixel_accept |=> s1_valid)
    else $error("accepted pixel did not enter the read stage");

  // Transparent pixels carry a zero color.
  a_transparent_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !write_enable |-> pixel_color == '0)
    else $error("transparent pixel carries a nonzero color");

endmodule
